FILE: src/four_button_debounce_press_classifier_defines.svh
// Assertion macros for the four-button debounce classifier.
`ifndef FOUR_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define FOUR_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is held.
`define FBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("fbd assertion failed");
// Clocked check that also holds during reset.
`define FBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fbd assertion failed");
`else
`define FBD_ASSERT(lbl, clk, rst_n, prop)
`define FBD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: src/fbd_pkg.sv
package fbd_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;

    typedef enum logic [0:0] {
        CFG_DEBOUNCE_MS   = 1'b0,
        CFG_LONG_PRESS_MS = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_UP_SHORT     = 3'd1,
        EV_DOWN_SHORT   = 3'd2,
        EV_SELECT_SHORT = 3'd3,
        EV_BACK_SHORT   = 3'd4,
        EV_SELECT_LONG  = 3'd5,
        EV_BACK_LONG    = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_LONG  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } cfg_t;

    typedef kind_t  [NUM_BUTTONS-1:0] kind_vec_t;
    typedef event_t [NUM_BUTTONS-1:0] event_map_t;

    // Per button, order up, down, select, back; long on up/down reports nothing.
    localparam event_map_t SHORT_EVENT = '{EV_BACK_SHORT, EV_SELECT_SHORT,
                                           EV_DOWN_SHORT, EV_UP_SHORT};
    localparam event_map_t LONG_EVENT  = '{EV_BACK_LONG, EV_SELECT_LONG,
                                           EV_NONE, EV_NONE};

endpackage

FILE: src/four_button_debounce_press_classifier.sv
// Four-button debounce and press classifier. Each poll request carries the raw
// active-low levels of up, down, select and back plus a wrapping millisecond
// time, and yields exactly one event code (none, a short press of any button,
// or a long press of select or back). Four button lanes evaluate in parallel
// and a priority merge picks the first event and decides which lanes update.
// One poll is accepted per clock unless the output is stalled; the result
// appears in an output register in the cycle after acceptance, and a new poll
// is taken while a result waits, as long as that result is taken in the same
// cycle. Configuration writes belong between polls.
module four_button_debounce_press_classifier (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [0:0]                cfg_addr,
    input  logic [fbd_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [39:0]               s_tdata,   // raw_up, raw_down, raw_select, raw_back, now_ms
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata    // event_res[2:0], pad
);
    import fbd_pkg::*;

    `include "four_button_debounce_press_classifier_defines.svh"

    cfg_t                   cfg_reg;
    logic                   m_tvalid_reg;
    event_t                 event_reg;
    kind_vec_t              kinds;
    event_t                 event_next;
    logic [NUM_BUTTONS-1:0] commit_mask;
    logic                   accept;
    logic [TIME_W-1:0]      now_ms;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign now_ms   = s_tdata[NUM_BUTTONS +: TIME_W];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, event_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms   <= CFG_W'(50);
            cfg_reg.long_press_ms <= CFG_W'(1000);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_DEBOUNCE_MS:   cfg_reg.debounce_ms   <= cfg_wdata;
                CFG_LONG_PRESS_MS: cfg_reg.long_press_ms <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        fbd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg_reg),
            .level   (s_tdata[b]),
            .now_ms  (now_ms),
            .commit  (accept && commit_mask[b]),
            .kind    (kinds[b])
        );
    end

    fbd_merge u_merge (
        .kinds       (kinds),
        .event_res   (event_next),
        .commit_mask (commit_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            event_reg <= event_next;
        end
    end

    `FBD_ASSERT(a_accept_gives_result, aclk, aresetn, accept |=> m_tvalid)
    `FBD_ASSERT(a_commit_prefix, aclk, aresetn, (commit_mask & (commit_mask + NUM_BUTTONS'(1))) == '0)
    `FBD_ASSERT(a_none_commits_all, aclk, aresetn, (event_next == EV_NONE) |-> (&commit_mask))
    `FBD_ASSERT_ALWAYS(a_ready_when_empty, aclk, !m_tvalid_reg |-> s_tready)

endmodule

FILE: src/fbd_lane.sv
module fbd_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fbd_pkg::cfg_t              cfg,
    input  logic                       level,
    input  logic [fbd_pkg::TIME_W-1:0] now_ms,
    input  logic                       commit,
    output fbd_pkg::kind_t             kind
);
    import fbd_pkg::*;

    logic              prev_reg, prev_next;
    logic              stable_reg, stable_next;
    logic [TIME_W-1:0] change_reg, change_next;
    logic [TIME_W-1:0] press_reg, press_next;
    logic              long_reg, long_next;

    logic              raw_chg;
    logic              pressed_now;
    logic [TIME_W-1:0] steady_diff;
    logic [TIME_W-1:0] press_diff;

    always_comb begin
        raw_chg     = (level != prev_reg);
        prev_next   = level;
        change_next = raw_chg ? now_ms : change_reg;
        steady_diff = raw_chg ? '0 : (now_ms - change_reg);

        stable_next = stable_reg;
        press_next  = press_reg;
        long_next   = long_reg;
        pressed_now = 1'b0;
        kind        = KIND_NONE;

        if ((steady_diff > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms}) &&
            (level != stable_reg)) begin
            stable_next = level;
            if (!level) begin
                press_next  = now_ms;
                long_next   = 1'b0;
                pressed_now = 1'b1;
            end else if (!long_reg) begin
                kind = KIND_SHORT;
            end
        end

        press_diff = pressed_now ? '0 : (now_ms - press_reg);
        if (!stable_next && !long_next &&
            (press_diff > {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms})) begin
            long_next = 1'b1;
            kind      = KIND_LONG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b1;
            stable_reg <= 1'b1;
            change_reg <= '0;
            press_reg  <= '0;
            long_reg   <= 1'b0;
        end else if (commit) begin
            prev_reg   <= prev_next;
            stable_reg <= stable_next;
            change_reg <= change_next;
            press_reg  <= press_next;
            long_reg   <= long_next;
        end
    end

endmodule

FILE: src/fbd_merge.sv
module fbd_merge (
    input  fbd_pkg::kind_vec_t               kinds,
    output fbd_pkg::event_t                  event_res,
    output logic [fbd_pkg::NUM_BUTTONS-1:0]  commit_mask
);
    import fbd_pkg::*;

    logic stop;

    // First reporting button wins; later buttons keep their state.
    always_comb begin
        stop        = 1'b0;
        event_res   = EV_NONE;
        commit_mask = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            commit_mask[b] = !stop;
            if (!stop) begin
                if (kinds[b] == KIND_SHORT) begin
                    event_res = SHORT_EVENT[b];
                    stop      = 1'b1;
                end else if (kinds[b] == KIND_LONG && LONG_EVENT[b] != EV_NONE) begin
                    event_res = LONG_EVENT[b];
                    stop      = 1'b1;
                end
            end
        end
    end

endmodule
